FILE: sv/fixed_point_q24_8_alu_unit_defines.svh
// Assertion macros for the fixed-point ALU, used by fpq_back.
// Needs a clk in the scope of each use, and an rst_n for FPQ_ASSERT.
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH

// Checked while out of reset.
`define FPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define FPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/fpq_pkg.sv
// Types and constants for the fixed-point ALU.
// No dependencies.
package fpq_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;
  localparam int OUT_BITS      = 32;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_NE       = 4'd8,
    CMD_EQ       = 4'd9,
    CMD_MAX      = 4'd10,
    CMD_MIN      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } fpq_cmd_t;

  // Side data that travels with an item through the divider stages.
  typedef struct packed {
    logic                is_div;
    logic                neg_q;
    logic                dz;
    logic                flag;
    logic [OUT_BITS-1:0] res;
  } fpq_side_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                flag;
    logic                dz;
  } fpq_res_t;

endpackage

FILE: sv/fpq_in_if.sv
// Input channel of the fixed-point ALU: command and two raw operands.
// Depends on nothing.
interface fpq_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

FILE: sv/fpq_out_if.sv
// Result channel of the fixed-point ALU.
// Depends on nothing.
interface fpq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        compare_flag;
  logic        divide_by_zero;

  modport source (output valid, result_value, compare_flag, divide_by_zero, input ready);
  modport sink   (input valid, result_value, compare_flag, divide_by_zero, output ready);
endinterface

FILE: sv/fpq_front.sv
// First two stages: decode, simple operations, multiply and divider set-up.
// Depends on fpq_pkg and fpq_in_if.
module fpq_front import fpq_pkg::*; #(
  parameter int FB = FRAC_BITS_DEF,
  parameter int WB = WORD_BITS_DEF,
  parameter int DW = WB + FB
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  fpq_in_if.sink        in_ch,
  output logic          v_o,
  output logic [DW-1:0] nq_o,
  output logic [WB-1:0] d_o,
  output fpq_side_t     side_o
);

  logic signed [WB-1:0]   a, b, r;
  logic [WB-1:0]          abs_a, abs_b;
  fpq_side_t              side_nxt;
  fpq_cmd_t               cmd;

  logic                   v1_r, is_mul1_r;
  logic signed [2*WB-1:0] prod1_r;
  fpq_side_t              side1_r;
  logic [DW-1:0]          nq1_r;
  logic [WB-1:0]          d1_r;
  logic signed [2*WB-1:0] prod_sh;
  logic signed [WB-1:0]   mul_w;
  fpq_side_t              side2_nxt;

  assign in_ch.ready = en;
  assign cmd = fpq_cmd_t'(in_ch.command);
  assign a   = $signed(in_ch.operand_a[WB-1:0]);
  assign b   = $signed(in_ch.operand_b[WB-1:0]);
  assign abs_a = a[WB-1] ? WB'(-a) : WB'(a);
  assign abs_b = b[WB-1] ? WB'(-b) : WB'(b);

  always_comb begin
    r = '0;
    side_nxt = '0;
    case (cmd)
      CMD_ADD:      r = a + b;
      CMD_SUB:      r = a - b;
      CMD_GT:       side_nxt.flag = (a > b);
      CMD_LT:       side_nxt.flag = (a < b);
      CMD_GE:       side_nxt.flag = (a >= b);
      CMD_LE:       side_nxt.flag = (a <= b);
      CMD_NE:       side_nxt.flag = (a != b);
      CMD_EQ:       side_nxt.flag = (a == b);
      CMD_MAX:      r = (a > b) ? a : b;
      CMD_MIN:      r = (a < b) ? a : b;
      CMD_INC:      r = a + WB'(1);
      CMD_DEC:      r = a - WB'(1);
      CMD_FROM_INT: r = a <<< FB;
      CMD_TO_INT:   r = a >>> FB;
      CMD_DIV: begin
        side_nxt.is_div = 1'b1;
        side_nxt.dz     = (b == '0);
        side_nxt.neg_q  = a[WB-1] ^ b[WB-1];
      end
      default:      r = '0;
    endcase
    side_nxt.res = OUT_BITS'(r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v_o  <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v_o  <= v1_r;
    end
  end

  assign prod_sh = prod1_r >>> FB;
  assign mul_w   = prod_sh[WB-1:0];

  // Put the scaled product in place of the result for a multiply
  always_comb begin
    side2_nxt = side1_r;
    if (is_mul1_r) begin
      side2_nxt.res = OUT_BITS'(mul_w);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_mul1_r <= (cmd == CMD_MUL);
      prod1_r   <= a * b;
      side1_r   <= side_nxt;
      nq1_r     <= {abs_a, {FB{1'b0}}};
      d1_r      <= abs_b;
      nq_o      <= nq1_r;
      d_o       <= d1_r;
      side_o    <= side2_nxt;
    end
  end

endmodule

FILE: sv/fpq_div_stage.sv
// One restoring divide step: settles one quotient bit and passes the item on.
// Depends on fpq_pkg.
module fpq_div_stage import fpq_pkg::*; #(
  parameter int WB = WORD_BITS_DEF,
  parameter int DW = WORD_BITS_DEF + FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [WB-1:0] rem_i,
  input  logic [DW-1:0] nq_i,
  input  logic [WB-1:0] d_i,
  input  fpq_side_t     side_i,
  output logic          v_o,
  output logic [WB-1:0] rem_o,
  output logic [DW-1:0] nq_o,
  output logic [WB-1:0] d_o,
  output fpq_side_t     side_o
);

  logic [WB+1:0] trial;
  logic [WB:0]   shifted;
  logic          ge;

  assign shifted = {rem_i, nq_i[DW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, d_i};
  assign ge      = ~trial[WB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? trial[WB-1:0] : shifted[WB-1:0];
      nq_o   <= {nq_i[DW-2:0], ge};
      d_o    <= d_i;
      side_o <= side_i;
    end
  end

endmodule

FILE: sv/fpq_back.sv
// Quotient sign fix, result select, output register and skid stage.
// Depends on fpq_pkg, fpq_out_if and the assertion macros.
`include "fixed_point_q24_8_alu_unit_defines.svh"
module fpq_back import fpq_pkg::*; #(
  parameter int WB = WORD_BITS_DEF,
  parameter int DW = WORD_BITS_DEF + FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          v_i,
  input  logic [DW-1:0] q_i,
  input  fpq_side_t     side_i,
  output logic          en,
  fpq_out_if.source     out_ch
);

  logic [DW-1:0] qs;
  logic [WB-1:0] qw;
  fpq_res_t      res_nxt, od_r, sk_r;
  logic          ov_r, sk_v_r, leave;

  assign qs = side_i.neg_q ? DW'(-q_i) : q_i;
  assign qw = qs[WB-1:0];

  always_comb begin
    res_nxt.flag  = side_i.flag;
    res_nxt.dz    = side_i.dz;
    res_nxt.value = side_i.res;
    if (side_i.is_div) begin
      res_nxt.value = side_i.dz ? '0 : OUT_BITS'($signed(qw));
    end
  end

  // The pipeline moves only while the skid stage is free.
  assign en    = ~sk_v_r;
  assign leave = en & v_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      sk_v_r <= 1'b0;
    end else if (!ov_r || out_ch.ready) begin
      if (sk_v_r) begin
        ov_r   <= 1'b1;
        sk_v_r <= 1'b0;
      end else begin
        ov_r <= leave;
      end
    end else if (leave) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || out_ch.ready) begin
      od_r <= sk_v_r ? sk_r : res_nxt;
    end else if (leave) begin
      sk_r <= res_nxt;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.result_value   = od_r.value;
  assign out_ch.compare_flag   = od_r.flag;
  assign out_ch.divide_by_zero = od_r.dz;

  `FPQ_ASSERT(a_skid_fill, $rose(sk_v_r) |-> $past(ov_r && !out_ch.ready), "skid filled without stall")
  `FPQ_ASSERT(a_skid_out, sk_v_r |-> ov_r, "skid holds an item behind an empty output")
  `FPQ_ASSERT(a_dz_zero, (ov_r && od_r.dz) |-> (od_r.value == '0 && !od_r.flag), "divide by zero not zero")
  `FPQ_ASSERT_ALWAYS(a_rst, !rst_n |=> (!ov_r && !sk_v_r), "output not cleared by reset")

endmodule

FILE: sv/fixed_point_q24_8_alu_unit.sv
// Pipelined signed fixed-point ALU (Q24.8 by default): one item may enter every
// cycle while the skid stage is free, and every command takes the same path
// through the front stages, the restoring divider that settles one quotient
// bit per stage, and the back end. Results leave in order; a one-entry skid
// stage lets one more item in after the result channel stalls. Depends on
// fpq_pkg, the channel interfaces, fpq_front, fpq_div_stage and fpq_back.
module fixed_point_q24_8_alu_unit import fpq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fpq_in_if.sink    in_ch,
  fpq_out_if.source out_ch
);

  localparam int DW = WORD_BITS + FRAC_BITS;

  logic                 en;
  logic                 v_s   [0:DW];
  logic [WORD_BITS-1:0] rem_s [0:DW];
  logic [DW-1:0]        nq_s  [0:DW];
  logic [WORD_BITS-1:0] d_s   [0:DW];
  fpq_side_t            side_s[0:DW];

  assign rem_s[0] = '0;

  fpq_front #(.FB(FRAC_BITS), .WB(WORD_BITS), .DW(DW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_ch  (in_ch),
    .v_o    (v_s[0]),
    .nq_o   (nq_s[0]),
    .d_o    (d_s[0]),
    .side_o (side_s[0])
  );

  for (genvar k = 0; k < DW; k++) begin : g_div
    fpq_div_stage #(.WB(WORD_BITS), .DW(DW)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (v_s[k]),
      .rem_i  (rem_s[k]),
      .nq_i   (nq_s[k]),
      .d_i    (d_s[k]),
      .side_i (side_s[k]),
      .v_o    (v_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .nq_o   (nq_s[k+1]),
      .d_o    (d_s[k+1]),
      .side_o (side_s[k+1])
    );
  end

  fpq_back #(.WB(WORD_BITS), .DW(DW)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_i    (v_s[DW]),
    .q_i    (nq_s[DW]),
    .side_i (side_s[DW]),
    .en     (en),
    .out_ch (out_ch)
  );

endmodule

FILE: dv/fixed_point_q24_8_alu_unit_tb.sv
// Testbench for the fixed-point ALU: directed table, then random bursts, checked
// against a behavioural predictor. Depends on fpq_pkg, the two channels, the ALU.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_unit_tb;
  import fpq_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = WORD_BITS_DEF + FRAC_BITS_DEF + 3;
  localparam int N_RANDOM = 830;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    fpq_cmd_t    cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic        known;
    fpq_res_t    res;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  fpq_in_if  in_ch();
  fpq_out_if out_ch();

  fixed_point_q24_8_alu_unit uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  fpq_res_t    pending_q[$];
  int          errors = 0;
  int          n_results = 0;
  int          n_divzero = 0;
  int          cycles = 0;
  bit          long_hold = 1'b0;
  vector_t     vectors[$];

  function automatic fpq_res_t alu_predict(fpq_cmd_t cmd, logic [31:0] ua, logic [31:0] ub);
    longint   a, b, r;
    fpq_res_t y;
    a = longint'($signed(ua));
    b = longint'($signed(ub));
    r = 0;
    y.flag = 1'b0;
    y.dz = 1'b0;
    case (cmd)
      CMD_ADD:      r = a + b;
      CMD_SUB:      r = a - b;
      CMD_MUL:      r = (a * b) >>> FB;
      CMD_DIV: begin
        if (b == 0) y.dz = 1'b1;
        else r = (a * (64'sd1 <<< FB)) / b;
      end
      CMD_GT:       y.flag = a > b;
      CMD_LT:       y.flag = a < b;
      CMD_GE:       y.flag = a >= b;
      CMD_LE:       y.flag = a <= b;
      CMD_NE:       y.flag = a != b;
      CMD_EQ:       y.flag = a == b;
      CMD_MAX:      r = (a > b) ? a : b;
      CMD_MIN:      r = (a < b) ? a : b;
      CMD_INC:      r = a + 1;
      CMD_DEC:      r = a - 1;
      CMD_FROM_INT: r = a <<< FB;
      default:      r = a >>> FB;
    endcase
    y.value = r[31:0];
    return y;
  endfunction

  function automatic fpq_res_t res_of(logic [31:0] v, logic f, logic d);
    fpq_res_t y;
    y.value = v;
    y.flag = f;
    y.dz = d;
    return y;
  endfunction

  task automatic add_vec(fpq_cmd_t c, logic [31:0] a, logic [31:0] b, logic k, fpq_res_t r);
    vector_t v;
    v.cmd = c;
    v.a = a;
    v.b = b;
    v.known = k;
    v.res = r;
    vectors.push_back(v);
  endtask

  task automatic send_item(fpq_cmd_t c, logic [31:0] a, logic [31:0] b);
    in_ch.valid <= 1'b1;
    in_ch.command <= c;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_q.push_back(alu_predict(c, a, b));
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 4) - 2;
      3: return $signed($urandom_range(0, 65535)) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall pattern, plus one long hold-off counted here
  initial begin
    int k;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        for (k = 0; k < 200; k++) @(posedge clk);
        long_hold = 1'b0;
      end
      if (($urandom_range(0, 99) < 30) && (cycles % 512 > 128)) out_ch.ready <= 1'b0;
      else out_ch.ready <= 1'b1;
    end
  end

  // Checker samples at the edge, before the nonblocking updates land
  always @(posedge clk) begin
    fpq_res_t want;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results <= n_results + 1;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: value %h", out_ch.result_value);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (want.dz) n_divzero <= n_divzero + 1;
        if (out_ch.result_value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, out_ch.result_value);
          errors++;
        end
        if (out_ch.compare_flag !== want.flag) begin
          $error("compare_flag: expected %b, got %b", want.flag, out_ch.compare_flag);
          errors++;
        end
        if (out_ch.divide_by_zero !== want.dz) begin
          $error("divide_by_zero: expected %b, got %b", want.dz, out_ch.divide_by_zero);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int       i, burst, gap, tail;
    fpq_cmd_t c;
    fpq_res_t got;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;

    add_vec(CMD_ADD, 32'h7FFF_FFFF, 32'd1, 1, res_of(32'h8000_0000, 0, 0));
    add_vec(CMD_SUB, 32'h8000_0000, 32'd1, 1, res_of(32'h7FFF_FFFF, 0, 0));
    add_vec(CMD_MUL, 32'h0000_0200, 32'h0000_0300, 1, res_of(32'h0000_0600, 0, 0));
    add_vec(CMD_MUL, 32'hFFFF_FFFF, 32'd1, 1, res_of(32'hFFFF_FFFF, 0, 0));
    add_vec(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0, '0);
    add_vec(CMD_DIV, 32'd5, 32'd0, 1, res_of(32'd0, 0, 1));
    add_vec(CMD_DIV, 32'h8000_0000, 32'd0, 1, res_of(32'd0, 0, 1));
    add_vec(CMD_DIV, 32'h0000_0100, 32'h0000_0200, 1, res_of(32'h0000_0080, 0, 0));
    add_vec(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, '0);
    add_vec(CMD_DIV, 32'hFFFF_FFFD, 32'd2, 0, '0);
    add_vec(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 0, '0);
    add_vec(CMD_GT, 32'h7FFF_FFFF, 32'h8000_0000, 1, res_of(32'd0, 1, 0));
    add_vec(CMD_LT, 32'h7FFF_FFFF, 32'h8000_0000, 1, res_of(32'd0, 0, 0));
    add_vec(CMD_GE, 32'd7, 32'd7, 1, res_of(32'd0, 1, 0));
    add_vec(CMD_LE, 32'hFFFF_FFFF, 32'd0, 1, res_of(32'd0, 1, 0));
    add_vec(CMD_NE, 32'd3, 32'd3, 1, res_of(32'd0, 0, 0));
    add_vec(CMD_EQ, 32'h8000_0000, 32'h8000_0000, 1, res_of(32'd0, 1, 0));
    add_vec(CMD_MAX, 32'd9, 32'd9, 0, '0);
    add_vec(CMD_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1, res_of(32'h8000_0000, 0, 0));
    add_vec(CMD_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, res_of(32'h8000_0000, 0, 0));
    add_vec(CMD_DEC, 32'h8000_0000, 32'd0, 1, res_of(32'h7FFF_FFFF, 0, 0));
    add_vec(CMD_FROM_INT, 32'h0080_0000, 32'd0, 1, res_of(32'h8000_0000, 0, 0));
    add_vec(CMD_TO_INT, 32'hFFFF_FFFF, 32'd0, 1, res_of(32'hFFFF_FFFF, 0, 0));
    add_vec(CMD_TO_INT, 32'h7FFF_FFFF, 32'd0, 1, res_of(32'h007F_FFFF, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[j]) begin
      got = alu_predict(vectors[j].cmd, vectors[j].a, vectors[j].b);
      if (vectors[j].known && got !== vectors[j].res) begin
        $error("table row %0d: expected %h, predictor %h", j, vectors[j].res, got);
        errors++;
      end
      send_item(vectors[j].cmd, vectors[j].a, vectors[j].b);
    end

    // Drain before the random part
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);

    i = 0;
    while (i < N_RANDOM) begin
      burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      for (int k = 0; k < burst && i < N_RANDOM; k++, i++) begin
        if (i == 300) long_hold = 1'b1;
        c = fpq_cmd_t'($urandom_range(0, 15));
        send_item(c, rand_operand(), ($urandom_range(0, 9) == 0) ? 32'd0 : rand_operand());
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (i > 600 && i < 620) begin
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    for (tail = 0; tail < 2 * LATENCY; tail++) @(posedge clk);

    $display("covered %0d items over all 16 commands; %0d results, %0d divide-by-zero",
             vectors.size() + N_RANDOM, n_results, n_divzero);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
